// File: hdl/asa_pkg.sv
package asa_pkg;

  localparam int unsigned ARENA_BYTES  = 65536;
  localparam int unsigned MAX_RECORDS  = 256;
  localparam int unsigned HEADER_BYTES = 16;
  localparam int unsigned HEADER_ALIGN = 8;

  localparam int unsigned ADDR_W  = 17;
  localparam int unsigned START_W = 16;
  localparam int unsigned CNT_W   = $clog2(MAX_RECORDS + 1);
  localparam int unsigned IDX_W   = $clog2(MAX_RECORDS);

  localparam logic [1:0] ACT_ALLOC     = 2'd0;
  localparam logic [1:0] ACT_FREE_LAST = 2'd1;
  localparam logic [1:0] ACT_FREE_AT   = 2'd2;
  localparam logic [1:0] ACT_RESET     = 2'd3;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_ALIGN = 3'd1;
  localparam logic [2:0] ST_NO_ROOM   = 3'd2;
  localparam logic [2:0] ST_EMPTY     = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND = 3'd4;

  typedef struct packed {
    logic [START_W-1:0] start;
    logic [ADDR_W-1:0]  prev;
  } rec_t;

  // push: shift down, new record into cell 0
  // pop:  shift up
  // rot:  shift up, cell 0 wraps into the last live cell
  typedef struct packed {
    logic push;
    logic pop;
    logic rot;
  } stk_ctrl_t;

endpackage

// File: hdl/asa_cell.sv
module asa_cell (
  input  logic              clk_i,
  input  asa_pkg::stk_ctrl_t ctrl_i,
  input  logic              is_last_i,
  input  asa_pkg::rec_t     up_i,
  input  asa_pkg::rec_t     down_i,
  input  asa_pkg::rec_t     wrap_i,
  output asa_pkg::rec_t     rec_o
);
  import asa_pkg::*;

  rec_t rec_d, rec_q;

  always_comb begin
    rec_d = rec_q;
    if (ctrl_i.push) begin
      rec_d = up_i;
    end else if (ctrl_i.pop) begin
      rec_d = down_i;
    end else if (ctrl_i.rot) begin
      rec_d = is_last_i ? wrap_i : down_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rec_q <= rec_d;
  end

  assign rec_o = rec_q;

endmodule

// File: hdl/asa_stack.sv
module asa_stack (
  input  logic                      clk_i,
  input  asa_pkg::stk_ctrl_t        ctrl_i,
  input  asa_pkg::rec_t             push_rec_i,
  input  logic [asa_pkg::IDX_W-1:0] last_idx_i,
  output asa_pkg::rec_t             top_rec_o
);
  import asa_pkg::*;

  rec_t recs [MAX_RECORDS];

  for (genvar k = 0; k < MAX_RECORDS; k++) begin : g_cell
    rec_t up, down;
    logic is_last;

    if (k == 0) begin : g_first
      assign up = push_rec_i;
    end else begin : g_mid_up
      assign up = recs[k-1];
    end

    if (k == MAX_RECORDS - 1) begin : g_end
      assign down = '0;
    end else begin : g_mid_down
      assign down = recs[k+1];
    end

    assign is_last = (last_idx_i == IDX_W'(k));

    asa_cell u_cell (
      .clk_i     (clk_i),
      .ctrl_i    (ctrl_i),
      .is_last_i (is_last),
      .up_i      (up),
      .down_i    (down),
      .wrap_i    (recs[0]),
      .rec_o     (recs[k])
    );
  end

  assign top_rec_o = recs[0];

endmodule

// File: hdl/aligned_stack_allocator_core.sv
// Stack allocator over a 64 KiB arena of byte offsets. Each request beat gives one
// result beat. For allocate, free-last and reset the aligned start is computed in the
// accept cycle, the limit check and the record push happen in the next. Free-at walks
// the stack: the record chain rotates one cell per cycle past a single compare at the
// top cell, so the walk length is set by how deep the matching record sits (a miss
// walks all live records). A new request is accepted once the previous one has
// finished and its result has moved into the output register; if that register is
// still occupied, the result waits in a second register and the input stays blocked
// until the consumer takes the earlier beat and the waiting one moves up.
module aligned_stack_allocator_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,

  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [asa_pkg::ADDR_W-1:0] cfg_data_i,

  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [1:0]                 action_i,
  input  logic [asa_pkg::ADDR_W-1:0] request_size_i,
  input  logic [asa_pkg::ADDR_W-1:0] alignment_i,
  input  logic [asa_pkg::ADDR_W-1:0] free_address_i,

  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [asa_pkg::START_W-1:0] start_address_o,
  output logic [2:0]                 status_o,
  output logic [asa_pkg::ADDR_W-1:0] used_bytes_o
);
  import asa_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_EXEC   = 2'd1;
  localparam logic [1:0] S_SEARCH = 2'd2;
  localparam logic [1:0] S_HOLD   = 2'd3;

  localparam int unsigned POS_W = ADDR_W + 1;
  localparam int unsigned SUM_W = ADDR_W + 2;

  logic [1:0]        state_d, state_q;
  logic [1:0]        act_d, act_q;
  logic [ADDR_W-1:0] size_d, size_q;
  logic [ADDR_W-1:0] addr_d, addr_q;
  logic [POS_W-1:0]  pos_d, pos_q;
  logic              bad_d, bad_q;
  logic [ADDR_W-1:0] marker_d, marker_q;
  logic [CNT_W-1:0]  count_d, count_q;
  logic [CNT_W-1:0]  walk_d, walk_q;
  logic [ADDR_W-1:0] arena_d, arena_q;

  logic              out_valid_d, out_valid_q;
  logic [START_W-1:0] ostart_d, ostart_q;
  logic [2:0]        ostat_d, ostat_q;
  logic [ADDR_W-1:0] oused_d, oused_q;
  logic [START_W-1:0] hstart_d, hstart_q;
  logic [2:0]        hstat_d, hstat_q;
  logic [ADDR_W-1:0] hused_d, hused_q;

  stk_ctrl_t         sctrl;
  rec_t              push_rec, top_rec;
  logic [IDX_W-1:0]  last_idx;

  logic [ADDR_W-1:0] align_eff, align_mask, limit;
  logic [CNT_W-1:0]  count_m1;
  logic [SUM_W-1:0]  end_pos;
  logic              done;
  logic [START_W-1:0] res_start;
  logic [2:0]        res_stat;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);

  assign limit      = (arena_q > ADDR_W'(ARENA_BYTES)) ? ADDR_W'(ARENA_BYTES) : arena_q;
  assign align_eff  = (alignment_i < ADDR_W'(HEADER_ALIGN)) ? ADDR_W'(HEADER_ALIGN)
                                                             : alignment_i;
  assign align_mask = align_eff - ADDR_W'(1);
  assign end_pos    = SUM_W'(pos_q) + SUM_W'(size_q);
  assign count_m1   = count_q - CNT_W'(1);
  assign last_idx   = count_m1[IDX_W-1:0];

  assign push_rec.start = pos_q[START_W-1:0];
  assign push_rec.prev  = marker_q;

  always_comb begin
    state_d     = state_q;
    act_d       = act_q;
    size_d      = size_q;
    addr_d      = addr_q;
    pos_d       = pos_q;
    bad_d       = bad_q;
    marker_d    = marker_q;
    count_d     = count_q;
    walk_d      = walk_q;
    arena_d     = arena_q;
    out_valid_d = out_valid_q && !out_ready_i;
    ostart_d    = ostart_q;
    ostat_d     = ostat_q;
    oused_d     = oused_q;
    hstart_d    = hstart_q;
    hstat_d     = hstat_q;
    hused_d     = hused_q;
    sctrl       = '0;
    done        = 1'b0;
    res_start   = '0;
    res_stat    = ST_OK;

    if (cfg_valid_i) begin
      arena_d = cfg_data_i;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          act_d   = action_i;
          size_d  = request_size_i;
          addr_d  = free_address_i;
          bad_d   = (alignment_i == '0) ||
                    ((alignment_i & (alignment_i - ADDR_W'(1))) != '0);
          pos_d   = (POS_W'(marker_q) + POS_W'(align_mask) + POS_W'(HEADER_BYTES)) &
                    ~POS_W'(align_mask);
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        done = 1'b1;
        case (act_q)
          ACT_ALLOC: begin
            if (bad_q) begin
              res_stat = ST_BAD_ALIGN;
            end else if (count_q >= CNT_W'(MAX_RECORDS)) begin
              res_stat = ST_NO_ROOM;
            end else if ((end_pos > SUM_W'(limit)) ||
                         (pos_q > POS_W'({START_W{1'b1}}))) begin
              res_stat = ST_NO_ROOM;
            end else begin
              sctrl.push = 1'b1;
              count_d    = count_q + CNT_W'(1);
              marker_d   = end_pos[ADDR_W-1:0];
              res_start  = pos_q[START_W-1:0];
            end
          end
          ACT_FREE_LAST: begin
            if (count_q == '0) begin
              res_stat = ST_EMPTY;
            end else begin
              sctrl.pop = 1'b1;
              count_d   = count_m1;
              marker_d  = top_rec.prev;
            end
          end
          ACT_FREE_AT: begin
            if (count_q == '0) begin
              res_stat = ST_EMPTY;
            end else if ((addr_q == '0) || (addr_q > marker_q)) begin
              res_stat = ST_NOT_FOUND;
            end else begin
              done    = 1'b0;
              walk_d  = '0;
              state_d = S_SEARCH;
            end
          end
          default: begin
            marker_d = '0;
            count_d  = '0;
          end
        endcase
      end
      S_SEARCH: begin
        if (walk_q == count_q) begin
          // full turn: chain is back in its original order
          done     = 1'b1;
          res_stat = ST_NOT_FOUND;
        end else if (ADDR_W'(top_rec.start) == addr_q) begin
          // records walked past end up at or above the new count and drop off
          done      = 1'b1;
          sctrl.pop = 1'b1;
          marker_d  = top_rec.prev;
          count_d   = count_m1 - walk_q;
        end else begin
          sctrl.rot = 1'b1;
          walk_d    = walk_q + CNT_W'(1);
        end
      end
      S_HOLD: begin
        if (out_ready_i) begin
          out_valid_d = 1'b1;
          ostart_d    = hstart_q;
          ostat_d     = hstat_q;
          oused_d     = hused_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (done) begin
      if (!out_valid_q || out_ready_i) begin
        out_valid_d = 1'b1;
        ostart_d    = res_start;
        ostat_d     = res_stat;
        oused_d     = marker_d;
        state_d     = S_IDLE;
      end else begin
        hstart_d = res_start;
        hstat_d  = res_stat;
        hused_d  = marker_d;
        state_d  = S_HOLD;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      marker_q    <= '0;
      count_q     <= '0;
      walk_q      <= '0;
      arena_q     <= ADDR_W'(ARENA_BYTES);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      marker_q    <= marker_d;
      count_q     <= count_d;
      walk_q      <= walk_d;
      arena_q     <= arena_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q    <= act_d;
    size_q   <= size_d;
    addr_q   <= addr_d;
    pos_q    <= pos_d;
    bad_q    <= bad_d;
    ostart_q <= ostart_d;
    ostat_q  <= ostat_d;
    oused_q  <= oused_d;
    hstart_q <= hstart_d;
    hstat_q  <= hstat_d;
    hused_q  <= hused_d;
  end

  asa_stack u_stack (
    .clk_i      (clk_i),
    .ctrl_i     (sctrl),
    .push_rec_i (push_rec),
    .last_idx_i (last_idx),
    .top_rec_o  (top_rec)
  );

  assign out_valid_o     = out_valid_q;
  assign start_address_o = ostart_q;
  assign status_o        = ostat_q;
  assign used_bytes_o    = oused_q;

endmodule
